// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the disjoint-set union engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/ufmc_pkg.sv =====
// Shared constants and controller/datapath interface types of the union-find engine.
`default_nettype none
package ufmc_pkg;

   localparam int ID_WIDTH           = 10;
   localparam int GROUP_WIDTH        = 11;
   localparam int NODE_COUNT_DEFAULT = 1024;
   localparam int RECIP_SHIFT        = 20;
   localparam logic [GROUP_WIDTH-1:0] OUT_MAX = 11'd2047;

   // Commands from the controller to the datapath, one group per cycle.
   typedef struct packed {
      logic load;     // capture the two node ids of an accepted transaction
      logic sel_b;    // the find works on the second node
      logic red_mul;  // register the quotient estimate of the id wrap
      logic red_fix;  // form the wrapped node id into the walk pointer
      logic clr;      // clear one parent-table entry during the reset sweep
      logic rd_x;     // read the parent word of the walk pointer
      logic chk_x;    // evaluate the parent word of the walk pointer
      logic hop;      // apply one path-halving step
      logic rd_sa;    // read the size of the first root
      logic rd_sb;    // capture the first size, read the size of the second root
      logic link;     // join the two roots by size
      logic result;   // update the running maximum and load the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;  // the sweep is at the last table entry
      logic x_done;    // the walk pointer is a root, or a node never seen
   } ctrl_status_type;

endpackage
`default_nettype wire

// ===== hdl/union_find_max_component.sv =====
// Top level of the disjoint-set union engine with a running largest-component size.
// Each transaction names two node ids (wrapped modulo NODE_COUNT) and joins their sets,
// using path-halving finds and union by size; the result is the largest component
// size seen so far, saturated at 2047. After reset the block sweeps the parent table
// to clear its seen flags entry by entry, with req_stall high. One transaction is in
// work at a time, and the next transaction can be taken in the cycle after the result
// is loaded. Union by size keeps every tree at most log2(NODE_COUNT) deep, and a
// halving step skips two levels; each halving step waits on a registered read of the
// parent table.
// A finished result waits in an output register while the next transaction is taken.
`default_nettype none
`include "assert_macros.svh"
module union_find_max_component #(
   parameter int NODE_COUNT = ufmc_pkg::NODE_COUNT_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [ufmc_pkg::ID_WIDTH-1:0]      req_first_node,
   input  wire logic [ufmc_pkg::ID_WIDTH-1:0]      req_second_node,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [ufmc_pkg::GROUP_WIDTH-1:0]   rsp_largest_group
);

   ufmc_pkg::ctrl_cmd_type    cmd;
   ufmc_pkg::ctrl_status_type status;

   ufmc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .status   (status)
   );

   ufmc_datapath #(
      .NODE_COUNT(NODE_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_first_node   (req_first_node),
      .req_second_node  (req_second_node),
      .rsp_largest_group(rsp_largest_group)
   );

   `ASSERT_CLK(a_clear_blocks_input, clock, reset, cmd.clr |-> req_stall, "transaction accepted during clear sweep")
   `ASSERT_CLK(a_no_result_overwrite, clock, reset, cmd.result |-> (!rsp_valid || !rsp_stall), "result loaded over a waiting one")
   `ASSERT_NEXT(a_accept_starts_find, clock, reset, (req_valid && !req_stall), (cmd.red_mul && !cmd.sel_b), "accepted transaction did not start the first find")
   `ASSERT_NEXT(a_result_shown, clock, reset, cmd.result, rsp_valid, "loaded result not presented")

endmodule
`default_nettype wire

// ===== hdl/ufmc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module ufmc_ram #(
   parameter int WIDTH = ufmc_pkg::GROUP_WIDTH,
   parameter int DEPTH = ufmc_pkg::NODE_COUNT_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/ufmc_datapath.sv =====
// Datapath of the union-find engine: id wrap, parent and size tables, union and maximum.
`default_nettype none
module ufmc_datapath #(
   parameter int NODE_COUNT = ufmc_pkg::NODE_COUNT_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ufmc_pkg::ctrl_cmd_type             cmd,
   output ufmc_pkg::ctrl_status_type               status,
   input  wire logic [ufmc_pkg::ID_WIDTH-1:0]      req_first_node,
   input  wire logic [ufmc_pkg::ID_WIDTH-1:0]      req_second_node,
   output logic      [ufmc_pkg::GROUP_WIDTH-1:0]   rsp_largest_group
);

   localparam int IDX_WIDTH  = $clog2(NODE_COUNT);
   localparam int SIZE_WIDTH = $clog2(NODE_COUNT + 1);
   localparam int WORD_WIDTH = IDX_WIDTH + 1;
   localparam int CMP_WIDTH  = (SIZE_WIDTH > ufmc_pkg::GROUP_WIDTH) ?
                               SIZE_WIDTH : ufmc_pkg::GROUP_WIDTH;
   localparam bit NEED_WRAP  = NODE_COUNT < (2 ** ufmc_pkg::ID_WIDTH);
   localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(NODE_COUNT - 1);

   logic [ufmc_pkg::ID_WIDTH-1:0]    id_a_ff, id_b_ff, id_sel;
   logic [IDX_WIDTH-1:0]             x_ff, ra_ff, rb_ff, clr_cnt_ff;
   logic [IDX_WIDTH-1:0]             node_wrapped;
   logic [SIZE_WIDTH-1:0]            sa_ff, merged_ff, best_ff;
   logic [SIZE_WIDTH-1:0]            merged_in, best_in, size_sum;
   logic [ufmc_pkg::GROUP_WIDTH-1:0] out_ff, out_in;
   logic [CMP_WIDTH-1:0]             best_wide;

   logic                  pr_wr_en;
   logic [IDX_WIDTH-1:0]  pr_wr_addr, pr_rd_addr, pr_par;
   logic [WORD_WIDTH-1:0] pr_wr_data, pr_rdata;
   logic                  pr_seen;

   logic                  sz_wr_en;
   logic [IDX_WIDTH-1:0]  sz_wr_addr, sz_rd_addr;
   logic [SIZE_WIDTH-1:0] sz_wr_data, sz_rdata;

   logic                  a_wins, roots_differ;
   logic [IDX_WIDTH-1:0]  winner, loser;

   assign id_sel = cmd.sel_b ? id_b_ff : id_a_ff;

   // Ids wrap modulo the node count. Below the id range this is a reciprocal
   // multiply followed by one compare-and-subtract correction.
   if (NEED_WRAP) begin : g_wrap
      localparam int PROD_WIDTH = ufmc_pkg::ID_WIDTH + ufmc_pkg::RECIP_SHIFT;
      localparam int BACK_WIDTH = 2 * ufmc_pkg::ID_WIDTH;
      localparam logic [ufmc_pkg::RECIP_SHIFT-1:0] RECIP =
         ufmc_pkg::RECIP_SHIFT'((2 ** ufmc_pkg::RECIP_SHIFT) / NODE_COUNT);
      localparam logic [ufmc_pkg::ID_WIDTH:0] MODULUS = (ufmc_pkg::ID_WIDTH + 1)'(NODE_COUNT);

      logic [PROD_WIDTH-1:0]           prod;
      logic [ufmc_pkg::ID_WIDTH-1:0]   q_ff;
      logic [BACK_WIDTH-1:0]           back;
      logic [ufmc_pkg::ID_WIDTH:0]     rem, rem_fix;

      assign prod = {ufmc_pkg::RECIP_SHIFT'(0), id_sel} * {ufmc_pkg::ID_WIDTH'(0), RECIP};

      always_ff @(posedge clock) begin
         if (cmd.red_mul) begin
            q_ff <= prod[PROD_WIDTH-1:ufmc_pkg::RECIP_SHIFT];
         end
      end

      assign back    = {ufmc_pkg::ID_WIDTH'(0), q_ff} * BACK_WIDTH'(NODE_COUNT);
      assign rem     = {1'b0, id_sel} - back[ufmc_pkg::ID_WIDTH:0];
      assign rem_fix = (rem >= MODULUS) ? (rem - MODULUS) : rem;
      assign node_wrapped = rem_fix[IDX_WIDTH-1:0];
   end else begin : g_nowrap
      assign node_wrapped = IDX_WIDTH'(id_sel);
   end

   // Parent table word: seen flag on top of the parent id.
   assign pr_seen = pr_rdata[IDX_WIDTH];
   assign pr_par  = pr_rdata[IDX_WIDTH-1:0];

   assign status.x_done   = !pr_seen || (pr_par == x_ff);
   assign status.clr_last = (clr_cnt_ff == LAST_IDX);

   // Union by size; on a tie the first root goes under the second.
   assign a_wins       = sa_ff > sz_rdata;
   assign roots_differ = ra_ff != rb_ff;
   assign winner       = a_wins ? ra_ff : rb_ff;
   assign loser        = a_wins ? rb_ff : ra_ff;
   assign size_sum     = sa_ff + sz_rdata;
   assign merged_in    = roots_differ ? size_sum : sa_ff;

   assign pr_rd_addr = cmd.rd_x ? x_ff : pr_par;
   assign sz_rd_addr = cmd.rd_sa ? ra_ff : rb_ff;

   always_comb begin
      pr_wr_en   = 1'b0;
      pr_wr_addr = x_ff;
      pr_wr_data = {1'b1, x_ff};
      priority if (cmd.clr) begin
         pr_wr_en   = 1'b1;
         pr_wr_addr = clr_cnt_ff;
         pr_wr_data = '0;
      end else if (cmd.chk_x && !pr_seen) begin
         pr_wr_en = 1'b1;
      end else if (cmd.hop) begin
         pr_wr_en   = 1'b1;
         pr_wr_data = {1'b1, pr_par};
      end else if (cmd.link && roots_differ) begin
         pr_wr_en   = 1'b1;
         pr_wr_addr = loser;
         pr_wr_data = {1'b1, winner};
      end
   end

   always_comb begin
      sz_wr_en   = 1'b0;
      sz_wr_addr = x_ff;
      sz_wr_data = SIZE_WIDTH'(1);
      priority if (cmd.chk_x && !pr_seen) begin
         sz_wr_en = 1'b1;
      end else if (cmd.link && roots_differ) begin
         sz_wr_en   = 1'b1;
         sz_wr_addr = winner;
         sz_wr_data = size_sum;
      end
   end

   ufmc_ram #(
      .WIDTH(WORD_WIDTH),
      .DEPTH(NODE_COUNT)
   ) u_parent_ram (
      .clock  (clock),
      .wr_en  (pr_wr_en),
      .wr_addr(pr_wr_addr),
      .wr_data(pr_wr_data),
      .rd_addr(pr_rd_addr),
      .rd_data(pr_rdata)
   );

   ufmc_ram #(
      .WIDTH(SIZE_WIDTH),
      .DEPTH(NODE_COUNT)
   ) u_size_ram (
      .clock  (clock),
      .wr_en  (sz_wr_en),
      .wr_addr(sz_wr_addr),
      .wr_data(sz_wr_data),
      .rd_addr(sz_rd_addr),
      .rd_data(sz_rdata)
   );

   assign best_in   = (merged_ff > best_ff) ? merged_ff : best_ff;
   assign best_wide = CMP_WIDTH'(best_in);
   assign out_in    = (best_wide > CMP_WIDTH'(ufmc_pkg::OUT_MAX)) ?
                      ufmc_pkg::OUT_MAX : best_wide[ufmc_pkg::GROUP_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_a_ff <= req_first_node;
         id_b_ff <= req_second_node;
      end
      if (cmd.red_fix) begin
         x_ff <= node_wrapped;
      end else if (cmd.hop) begin
         x_ff <= pr_par;
      end
      if (cmd.chk_x && status.x_done) begin
         if (cmd.sel_b) begin
            rb_ff <= x_ff;
         end else begin
            ra_ff <= x_ff;
         end
      end
      if (cmd.rd_sb) begin
         sa_ff <= sz_rdata;
      end
      if (cmd.link) begin
         merged_ff <= merged_in;
      end
      if (cmd.result) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         best_ff    <= SIZE_WIDTH'(1);
      end else begin
         if (cmd.clr) begin
            clr_cnt_ff <= clr_cnt_ff + IDX_WIDTH'(1);
         end
         if (cmd.result) begin
            best_ff <= best_in;
         end
      end
   end

   assign rsp_largest_group = out_ff;

endmodule
`default_nettype wire

// ===== hdl/ufmc_ctrl.sv =====
// Controller state machine of the union-find engine.
`default_nettype none
module ufmc_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output ufmc_pkg::ctrl_cmd_type           cmd,
   input  wire ufmc_pkg::ctrl_status_type   status
);

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_RED_MUL = 4'd2;
   localparam logic [3:0] ST_RED_FIX = 4'd3;
   localparam logic [3:0] ST_READ_X  = 4'd4;
   localparam logic [3:0] ST_CHECK_X = 4'd5;
   localparam logic [3:0] ST_HOP     = 4'd6;
   localparam logic [3:0] ST_SIZE_A  = 4'd7;
   localparam logic [3:0] ST_SIZE_B  = 4'd8;
   localparam logic [3:0] ST_UNION   = 4'd9;
   localparam logic [3:0] ST_RESULT  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       sel_b_ff, sel_b_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      sel_b_in     = sel_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.sel_b    = sel_b_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               sel_b_in = 1'b0;
               state_in = ST_RED_MUL;
            end
         end
         ST_RED_MUL: begin
            cmd.red_mul = 1'b1;
            state_in    = ST_RED_FIX;
         end
         ST_RED_FIX: begin
            cmd.red_fix = 1'b1;
            state_in    = ST_READ_X;
         end
         ST_READ_X: begin
            cmd.rd_x = 1'b1;
            state_in = ST_CHECK_X;
         end
         ST_CHECK_X: begin
            cmd.chk_x = 1'b1;
            if (!status.x_done) begin
               state_in = ST_HOP;
            end else if (sel_b_ff) begin
               state_in = ST_SIZE_A;
            end else begin
               sel_b_in = 1'b1;
               state_in = ST_RED_MUL;
            end
         end
         ST_HOP: begin
            cmd.hop  = 1'b1;
            state_in = ST_CHECK_X;
         end
         ST_SIZE_A: begin
            cmd.rd_sa = 1'b1;
            state_in  = ST_SIZE_B;
         end
         ST_SIZE_B: begin
            cmd.rd_sb = 1'b1;
            state_in  = ST_UNION;
         end
         ST_UNION: begin
            cmd.link = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            // The running maximum moves only when the result can be loaded.
            if (slot_free) begin
               cmd.result   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sel_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_b_ff     <= sel_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire
